@@ hdl/mst_pkg.sv @@
// Shared types and constants for the matrix-shaper color transform.
package mst_pkg;

  localparam int NUM_CH      = 3;
  localparam int GAMMA_DEPTH = 256;
  localparam int GAMMA_AW    = $clog2(GAMMA_DEPTH);
  localparam int OTAB_DEPTH  = 8192;
  localparam int OTAB_AW     = $clog2(OTAB_DEPTH);
  localparam int FRAC_BITS   = 28;
  localparam int IDX_LSB     = FRAC_BITS - OTAB_AW;
  localparam int PROD_W      = 33;
  localparam int SUM_W       = 35;
  localparam int COEF_NUM    = 9;
  localparam int COEF_AW     = $clog2(COEF_NUM);
  localparam int MQ_DEPTH    = 4;
  localparam int MQ_AW       = $clog2(MQ_DEPTH);
  localparam int OQ_DEPTH    = 8;
  localparam int OQ_AW       = $clog2(OQ_DEPTH);

  localparam logic [1:0] OP_PIXEL = 2'd0;
  localparam logic [1:0] OP_GAMMA = 2'd1;
  localparam logic [1:0] OP_OTAB  = 2'd2;
  localparam logic [1:0] OP_COEF  = 2'd3;

  localparam logic CFG_SWAP  = 1'b0;
  localparam logic CFG_ALPHA = 1'b1;

  typedef enum logic [1:0] {
    KIND_PIXEL,
    KIND_GAMMA,
    KIND_OTAB,
    KIND_COEF
  } kind_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [7:0]         byte0;
    logic [7:0]         byte1;
    logic [7:0]         byte2;
    logic [7:0]         byte3;
    logic               frame_end;
    logic [1:0]         channel;
    logic [12:0]        entry_index;
    logic [15:0]        gamma_value;
    logic [7:0]         output_byte;
    logic signed [15:0] coefficient;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out0;
    logic [7:0] out1;
    logic [7:0] out2;
    logic [7:0] out3;
    logic       frame_end_out;
  } out_item_t;

  // Classified request as it travels from front to back.
  typedef struct packed {
    kind_t       kind;
    logic [1:0]  ch;
    logic [12:0] addr;
    logic [15:0] data;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        frame_end;
    logic        swap;
  } work_t;

  typedef struct packed {
    logic reserve;
    logic push;
  } back_ctl_t;

endpackage

@@ hdl/mst_front.sv @@
// Front end: configuration registers, request classification and input register.
module mst_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  mst_pkg::in_item_t request,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic              cfg_data,
  input  logic              mq_full,
  output logic              mq_push,
  output mst_pkg::work_t    mq_item
);

  logic           swap_red_blue;
  logic           alpha_present;
  logic           front_valid;
  mst_pkg::work_t front_item;
  mst_pkg::work_t item_next;
  logic           keep;
  logic           ready;
  logic           accept;

  always_comb begin
    item_next           = front_item;
    item_next.ch        = request.channel;
    item_next.addr      = request.entry_index;
    item_next.red       = swap_red_blue ? request.byte2 : request.byte0;
    item_next.green     = request.byte1;
    item_next.blue      = swap_red_blue ? request.byte0 : request.byte2;
    item_next.alpha     = alpha_present ? request.byte3 : 8'd0;
    item_next.frame_end = request.frame_end;
    item_next.swap      = swap_red_blue;
    case (request.operation)
      mst_pkg::OP_PIXEL: begin
        item_next.kind = mst_pkg::KIND_PIXEL;
        item_next.data = request.gamma_value;
        keep           = 1'b1;
      end
      mst_pkg::OP_GAMMA: begin
        item_next.kind = mst_pkg::KIND_GAMMA;
        item_next.data = request.gamma_value;
        keep           = (32'(request.channel) < mst_pkg::NUM_CH) &&
                         (32'(request.entry_index) < mst_pkg::GAMMA_DEPTH);
      end
      mst_pkg::OP_OTAB: begin
        item_next.kind = mst_pkg::KIND_OTAB;
        item_next.data = {8'd0, request.output_byte};
        keep           = (32'(request.channel) < mst_pkg::NUM_CH) &&
                         (32'(request.entry_index) < mst_pkg::OTAB_DEPTH);
      end
      mst_pkg::OP_COEF: begin
        item_next.kind = mst_pkg::KIND_COEF;
        item_next.data = request.coefficient;
        keep           = 32'(request.entry_index) < mst_pkg::COEF_NUM;
      end
      default: begin
        item_next.kind = mst_pkg::KIND_PIXEL;
        item_next.data = request.gamma_value;
        keep           = 1'b0;
      end
    endcase
  end

  assign ready   = !front_valid || !mq_full;
  assign full    = !ready;
  assign accept  = push && ready;
  assign mq_push = front_valid && !mq_full;
  assign mq_item = front_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid   <= 1'b0;
      swap_red_blue <= 1'b0;
      alpha_present <= 1'b1;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          mst_pkg::CFG_SWAP:  swap_red_blue <= cfg_data;
          mst_pkg::CFG_ALPHA: alpha_present <= cfg_data;
          default: ;
        endcase
      end
      // drop writes that address nothing
      if (ready) begin
        front_valid <= accept && keep;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_item <= item_next;
    end
  end

endmodule

@@ hdl/mst_queue.sv @@
// Short request queue between front and back.
module mst_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mst_pkg::work_t item_in,
  output logic           full,
  input  logic           pop,
  output mst_pkg::work_t item_out,
  output logic           empty
);

  mst_pkg::work_t                 mem [mst_pkg::MQ_DEPTH];
  logic [mst_pkg::MQ_AW-1:0]      wp;
  logic [mst_pkg::MQ_AW-1:0]      rp;
  logic [mst_pkg::MQ_AW:0]        count;
  logic                           do_push;
  logic                           do_pop;

  assign full     = count == (mst_pkg::MQ_AW + 1)'(mst_pkg::MQ_DEPTH);
  assign empty    = count == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign item_out = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wp <= wp + 1'b1;
      end
      if (do_pop) begin
        rp <= rp + 1'b1;
      end
      count <= count + (mst_pkg::MQ_AW + 1)'(do_push) - (mst_pkg::MQ_AW + 1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= item_in;
    end
  end

endmodule

@@ hdl/mst_back.sv @@
// Back end: gamma lookup, matrix multiply, clamp and output table lookup.
module mst_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                mq_empty,
  input  mst_pkg::work_t      mq_item,
  output logic                mq_pop,
  input  logic                room,
  output mst_pkg::back_ctl_t  ctl,
  output mst_pkg::out_item_t  res
);

  logic                              issue;
  logic                              v1, v2, v3, v4, v5;
  mst_pkg::work_t                    w1, w2, w3, w4, w5;
  logic [15:0]                       gam   [mst_pkg::NUM_CH];
  logic signed [15:0]                coef  [mst_pkg::COEF_NUM];
  logic signed [mst_pkg::PROD_W-1:0] prod  [mst_pkg::NUM_CH][mst_pkg::NUM_CH];
  logic signed [mst_pkg::SUM_W-1:0]  sum   [mst_pkg::NUM_CH];
  logic [mst_pkg::OTAB_AW-1:0]       idx_next [mst_pkg::NUM_CH];
  logic [mst_pkg::OTAB_AW-1:0]       idx   [mst_pkg::NUM_CH];
  logic [7:0]                        res8  [mst_pkg::NUM_CH];
  logic [31:0]                       addr_wide;
  logic [mst_pkg::OTAB_AW-1:0]       otab_waddr;

  // hold pixels back until the result queue has a slot reserved for them
  assign issue       = !mq_empty && (mq_item.kind != mst_pkg::KIND_PIXEL || room);
  assign mq_pop      = issue;
  assign ctl.reserve = issue && mq_item.kind == mst_pkg::KIND_PIXEL;
  assign ctl.push    = v5 && w5.kind == mst_pkg::KIND_PIXEL;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    w1 <= mq_item;
    w2 <= w1;
    w3 <= w2;
    w4 <= w3;
    w5 <= w4;
  end

  // stage 1: gamma tables, one memory per input channel
  for (genvar c = 0; c < mst_pkg::NUM_CH; c++) begin : g_gamma
    logic [15:0] gmem [mst_pkg::GAMMA_DEPTH];
    logic [7:0]  rd_addr;

    assign rd_addr = (c == 0) ? mq_item.red : (c == 1) ? mq_item.green : mq_item.blue;

    always_ff @(posedge clk) begin
      if (issue && mq_item.kind == mst_pkg::KIND_GAMMA && mq_item.ch == 2'(c)) begin
        gmem[mq_item.addr[mst_pkg::GAMMA_AW-1:0]] <= mq_item.data;
      end
      gam[c] <= gmem[rd_addr];
    end
  end

  // stage 2: coefficient update and the nine products
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mst_pkg::COEF_NUM; i++) begin
        coef[i] <= '0;
      end
    end else if (v1 && w1.kind == mst_pkg::KIND_COEF) begin
      coef[w1.addr[mst_pkg::COEF_AW-1:0]] <= $signed(w1.data);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < mst_pkg::NUM_CH; k++) begin
      for (int c = 0; c < mst_pkg::NUM_CH; c++) begin
        prod[k][c] <= $signed({1'b0, gam[k]}) * coef[k * 3 + c];
      end
    end
  end

  // stage 3: column sums
  always_ff @(posedge clk) begin
    for (int c = 0; c < mst_pkg::NUM_CH; c++) begin
      sum[c] <= mst_pkg::SUM_W'(prod[0][c]) + mst_pkg::SUM_W'(prod[1][c]) +
                mst_pkg::SUM_W'(prod[2][c]);
    end
  end

  // stage 4: clamp to the table range; a sum at or above one saturates
  always_comb begin
    for (int c = 0; c < mst_pkg::NUM_CH; c++) begin
      if (sum[c][mst_pkg::SUM_W-1]) begin
        idx_next[c] = '0;
      end else if (|sum[c][mst_pkg::SUM_W-2:mst_pkg::FRAC_BITS]) begin
        idx_next[c] = '1;
      end else begin
        idx_next[c] = sum[c][mst_pkg::FRAC_BITS-1:mst_pkg::IDX_LSB];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < mst_pkg::NUM_CH; c++) begin
      idx[c] <= idx_next[c];
    end
  end

  // stage 5: output tables, one memory per output channel
  assign addr_wide  = 32'(w4.addr);
  assign otab_waddr = addr_wide[mst_pkg::OTAB_AW-1:0];

  for (genvar c = 0; c < mst_pkg::NUM_CH; c++) begin : g_otab
    logic [7:0] omem [mst_pkg::OTAB_DEPTH];

    always_ff @(posedge clk) begin
      if (v4 && w4.kind == mst_pkg::KIND_OTAB && w4.ch == 2'(c)) begin
        omem[otab_waddr] <= w4.data[7:0];
      end
      res8[c] <= omem[idx[c]];
    end
  end

  assign res.out0          = w5.swap ? res8[2] : res8[0];
  assign res.out1          = res8[1];
  assign res.out2          = w5.swap ? res8[0] : res8[2];
  assign res.out3          = w5.alpha;
  assign res.frame_end_out = w5.frame_end;

endmodule

@@ hdl/mst_outq.sv @@
// Result queue with slot reservation for pixels in flight.
module mst_outq (
  input  logic                clk,
  input  logic                rst,
  input  mst_pkg::back_ctl_t  ctl,
  input  mst_pkg::out_item_t  res_in,
  output logic                room,
  output logic                empty,
  input  logic                pop,
  output mst_pkg::out_item_t  result
);

  mst_pkg::out_item_t        mem [mst_pkg::OQ_DEPTH];
  logic [mst_pkg::OQ_AW-1:0] wp;
  logic [mst_pkg::OQ_AW-1:0] rp;
  logic [mst_pkg::OQ_AW:0]   count;
  logic [mst_pkg::OQ_AW:0]   reserved;
  logic                      do_pop;

  assign empty  = count == '0;
  assign do_pop = pop && !empty;
  assign room   = reserved != (mst_pkg::OQ_AW + 1)'(mst_pkg::OQ_DEPTH);
  assign result = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      rp       <= '0;
      count    <= '0;
      reserved <= '0;
    end else begin
      if (ctl.push) begin
        wp <= wp + 1'b1;
      end
      if (do_pop) begin
        rp <= rp + 1'b1;
      end
      count    <= count + (mst_pkg::OQ_AW + 1)'(ctl.push) - (mst_pkg::OQ_AW + 1)'(do_pop);
      reserved <= reserved + (mst_pkg::OQ_AW + 1)'(ctl.reserve) -
                  (mst_pkg::OQ_AW + 1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wp] <= res_in;
    end
  end

endmodule

@@ hdl/matrix_shaper_color_transform.sv @@
// Top level of the matrix-shaper color transform.
//
//   channel   handshake          payload                  notes
//   request   push / full        request (in_item_t)      pixels and table writes
//   result    empty / pop        result (out_item_t)      one per pixel, in order
//   config    cfg_write          cfg_index, cfg_data      swap and alpha bits
//
// One request per cycle sustained while full stays low. A pixel passes, in order,
// through the input register, queue, gamma read, multiply, sum, clamp, output
// table read and result queue.
// Synchronous active-high reset; table contents are not cleared.
// A pixel leaves the queue only while the eight-slot result queue has a free
// slot, so a stalled result side fills the queues and then raises full.
module matrix_shaper_color_transform (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  mst_pkg::in_item_t  request,
  output logic               empty,
  input  logic               pop,
  output mst_pkg::out_item_t result,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic               cfg_data
);

  logic               mq_push;
  logic               mq_full;
  logic               mq_pop;
  logic               mq_empty;
  mst_pkg::work_t     mq_in;
  mst_pkg::work_t     mq_out;
  logic               room;
  mst_pkg::back_ctl_t ctl;
  mst_pkg::out_item_t res;

  mst_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .request   (request),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mq_full   (mq_full),
    .mq_push   (mq_push),
    .mq_item   (mq_in)
  );

  mst_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (mq_push),
    .item_in  (mq_in),
    .full     (mq_full),
    .pop      (mq_pop),
    .item_out (mq_out),
    .empty    (mq_empty)
  );

  mst_back u_back (
    .clk      (clk),
    .rst      (rst),
    .mq_empty (mq_empty),
    .mq_item  (mq_out),
    .mq_pop   (mq_pop),
    .room     (room),
    .ctl      (ctl),
    .res      (res)
  );

  mst_outq u_outq (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .res_in (res),
    .room   (room),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

@@ hdl/mst_checker.sv @@
// Port-level checks for the matrix-shaper color transform, bound to the top level.
module mst_checker (
  input logic               clk,
  input logic               rst,
  input logic               push,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input mst_pkg::out_item_t result
);

  // reset leaves both queues drained
  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not drained after reset");

  // a waiting result holds until taken
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed before pop");

  // full rises only after a request was taken
  a_full_cause: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(full)) |-> $past(push && !full))
    else $error("full rose without an accepted request");

  // results disappear only through pop
  a_empty_cause: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(empty)) |-> $past(pop))
    else $error("result vanished without pop");

endmodule

bind matrix_shaper_color_transform mst_checker u_mst_checker (
  .clk    (clk),
  .rst    (rst),
  .push   (push),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

@@ tb/tb_matrix_shaper_color_transform.sv @@
// Self-checking testbench for the matrix-shaper color transform top level.
module tb_matrix_shaper_color_transform;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT      = 23;
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 195;
  localparam int SETTLE_CYCLES = 32;
  localparam int STALL_LIMIT   = 2000;

  class shaper_scoreboard;
    logic [15:0]        gamma_lut [mst_pkg::NUM_CH][mst_pkg::GAMMA_DEPTH];
    logic [7:0]         out_lut [mst_pkg::NUM_CH][mst_pkg::OTAB_DEPTH];
    bit                 gamma_set [mst_pkg::NUM_CH][mst_pkg::GAMMA_DEPTH];
    bit                 otab_set [mst_pkg::NUM_CH][mst_pkg::OTAB_DEPTH];
    logic signed [15:0] coef [mst_pkg::COEF_NUM];
    logic               swap_rb;
    logic               alpha_on;
    mst_pkg::out_item_t expected_pixels[$];
    int                 errors;

    function new();
      foreach (coef[i]) coef[i] = '0;
      swap_rb  = 1'b0;
      alpha_on = 1'b1;
      errors   = 0;
    endfunction

    function void set_config(logic idx, logic val);
      if (idx == mst_pkg::CFG_SWAP) swap_rb = val;
      else alpha_on = val;
    endfunction

    // byte of the pixel that feeds input channel k
    function logic [7:0] chan_byte(mst_pkg::in_item_t it, int k);
      case (k)
        0:       return swap_rb ? it.byte2 : it.byte0;
        1:       return it.byte1;
        default: return swap_rb ? it.byte0 : it.byte2;
      endcase
    endfunction

    function int otab_index(mst_pkg::in_item_t it, int c);
      longint sum;
      sum = 0;
      for (int k = 0; k < mst_pkg::NUM_CH; k++)
        sum += longint'(gamma_lut[k][chan_byte(it, k)]) * longint'(coef[k * 3 + c]);
      // clamp below zero and at the top table entry
      if (sum <= 0) return 0;
      sum = sum >>> mst_pkg::IDX_LSB;
      return (sum > mst_pkg::OTAB_DEPTH - 1) ? mst_pkg::OTAB_DEPTH - 1 : int'(sum);
    endfunction

    function mst_pkg::out_item_t predict_pixel(mst_pkg::in_item_t it);
      logic [7:0]         mapped [mst_pkg::NUM_CH];
      mst_pkg::out_item_t px;
      for (int c = 0; c < mst_pkg::NUM_CH; c++) mapped[c] = out_lut[c][otab_index(it, c)];
      px.out0          = swap_rb ? mapped[2] : mapped[0];
      px.out1          = mapped[1];
      px.out2          = swap_rb ? mapped[0] : mapped[2];
      px.out3          = alpha_on ? it.byte3 : 8'h00;
      px.frame_end_out = it.frame_end;
      return px;
    endfunction

    function void note_request(mst_pkg::in_item_t it);
      case (it.operation)
        mst_pkg::OP_PIXEL: expected_pixels.push_back(predict_pixel(it));
        mst_pkg::OP_GAMMA: begin
          if (it.channel < mst_pkg::NUM_CH && it.entry_index < mst_pkg::GAMMA_DEPTH) begin
            gamma_lut[it.channel][it.entry_index] = it.gamma_value;
            gamma_set[it.channel][it.entry_index] = 1'b1;
          end
        end
        mst_pkg::OP_OTAB: begin
          if (it.channel < mst_pkg::NUM_CH && it.entry_index < mst_pkg::OTAB_DEPTH) begin
            out_lut[it.channel][it.entry_index]  = it.output_byte;
            otab_set[it.channel][it.entry_index] = 1'b1;
          end
        end
        default: begin
          if (it.entry_index < mst_pkg::COEF_NUM) coef[it.entry_index] = it.coefficient;
        end
      endcase
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_pixel(mst_pkg::out_item_t got);
      mst_pkg::out_item_t want;
      if (expected_pixels.size() == 0) begin
        $error("result with no pixel pending: %0h", got);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      compare("out0", want.out0, got.out0);
      compare("out1", want.out1, got.out1);
      compare("out2", want.out2, got.out2);
      compare("out3", want.out3, got.out3);
      compare("frame_end_out", 8'(want.frame_end_out), 8'(got.frame_end_out));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  mst_pkg::in_item_t  request = '0;
  logic               empty;
  logic               pop = 1'b0;
  mst_pkg::out_item_t result;
  logic               cfg_write = 1'b0;
  logic               cfg_index = 1'b0;
  logic               cfg_data = 1'b0;

  int src_idle_pct  = IDLE_PCT;
  int sink_idle_pct = IDLE_PCT;
  int stall_count   = 0;
  int sent          = 0;

  shaper_scoreboard sb;

  matrix_shaper_color_transform DUT (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .request   (request),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic mst_pkg::in_item_t random_fields();
    logic [95:0] r;
    r = {$urandom, $urandom, $urandom};
    return r[$bits(mst_pkg::in_item_t)-1:0];
  endfunction

  function automatic mst_pkg::in_item_t make_pixel(logic [7:0] b0, logic [7:0] b1,
                                                   logic [7:0] b2, logic [7:0] b3,
                                                   logic fe);
    mst_pkg::in_item_t it;
    it           = random_fields();
    it.operation = mst_pkg::OP_PIXEL;
    it.byte0     = b0;
    it.byte1     = b1;
    it.byte2     = b2;
    it.byte3     = b3;
    it.frame_end = fe;
    return it;
  endfunction

  function automatic mst_pkg::in_item_t make_write(logic [1:0] op, int ch, int idx, int val);
    mst_pkg::in_item_t it;
    it             = random_fields();
    it.operation   = op;
    it.channel     = ch[1:0];
    it.entry_index = idx[12:0];
    it.gamma_value = val[15:0];
    it.output_byte = val[7:0];
    it.coefficient = val[15:0];
    return it;
  endfunction

  // Mostly mid-range values so that sums land inside the table, not only at the clamps.
  function automatic int random_gamma();
    return ($urandom_range(99) < 70) ? $urandom_range(32768) : $urandom_range(65535);
  endfunction

  function automatic int random_coef();
    int r;
    r = $urandom_range(99);
    if (r < 50) return $urandom_range(4096);
    if (r < 75) return $urandom_range(12288) - 4096;
    return $urandom_range(65535);
  endfunction

  function automatic mst_pkg::in_item_t random_request();
    int r;
    r = $urandom_range(99);
    if (r < 70) return make_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                                  1'($urandom));
    if (r < 80) return make_write(mst_pkg::OP_GAMMA, $urandom_range(2), $urandom_range(255),
                                  random_gamma());
    if (r < 88) return make_write(mst_pkg::OP_OTAB, $urandom_range(2), $urandom_range(8191),
                                  $urandom_range(255));
    if (r < 96) return make_write(mst_pkg::OP_COEF, $urandom_range(3), $urandom_range(8),
                                  random_coef());
    // writes that must be dropped
    case ($urandom_range(3))
      0: return make_write(mst_pkg::OP_GAMMA, 3, $urandom_range(8191), $urandom);
      1: return make_write(mst_pkg::OP_GAMMA, $urandom_range(2), $urandom_range(8191, 256),
                           $urandom);
      2: return make_write(mst_pkg::OP_OTAB, 3, $urandom_range(8191), $urandom);
      default: return make_write(mst_pkg::OP_COEF, $urandom_range(3),
                                 $urandom_range(8191, 9), $urandom);
    endcase
  endfunction

  task automatic send_request(input mst_pkg::in_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    request <= it;
    do @(posedge clk); while (full);
    sb.note_request(it);
    sent++;
  endtask

  // Write any table entry this pixel would read that has not been written yet.
  task automatic send_pixel(input mst_pkg::in_item_t it);
    int idx;
    for (int k = 0; k < mst_pkg::NUM_CH; k++) begin
      idx = int'(sb.chan_byte(it, k));
      if (!sb.gamma_set[k][idx])
        send_request(make_write(mst_pkg::OP_GAMMA, k, idx, random_gamma()));
    end
    for (int c = 0; c < mst_pkg::NUM_CH; c++) begin
      idx = sb.otab_index(it, c);
      if (!sb.otab_set[c][idx])
        send_request(make_write(mst_pkg::OP_OTAB, c, idx, $urandom_range(255)));
    end
    send_request(it);
  endtask

  task automatic send_random();
    mst_pkg::in_item_t it;
    it = random_request();
    if (it.operation == mst_pkg::OP_PIXEL) send_pixel(it);
    else send_request(it);
  endtask

  // Hold off new requests until every pixel is out and the pipeline has settled.
  task automatic drain_pipeline();
    push <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) sb.check_pixel(result);
      pop <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) begin
        stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        stall_count <= stall_count + 1;
      end
    end
  end

  initial begin
    logic swap_plan [PHASES];
    logic alpha_plan [PHASES];
    int   phase_end;
    swap_plan  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
    alpha_plan = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Matrix still at reset: every channel maps through entry zero.
    send_pixel(make_pixel(8'h00, 8'hff, 8'h80, 8'h5a, 1'b0));
    send_request(make_write(mst_pkg::OP_COEF, 0, 0, 8192));
    send_request(make_write(mst_pkg::OP_COEF, 1, 4, 8192));
    send_request(make_write(mst_pkg::OP_COEF, 2, 8, 8192));
    send_request(make_write(mst_pkg::OP_GAMMA, 0, 255, 65535));
    send_request(make_write(mst_pkg::OP_GAMMA, 1, 128, 32768));
    send_request(make_write(mst_pkg::OP_GAMMA, 2, 127, 32767));
    send_request(make_write(mst_pkg::OP_GAMMA, 0, 1, 1));
    // above the top bound, exactly at it, and just below it
    send_pixel(make_pixel(8'hff, 8'h80, 8'h7f, 8'hff, 1'b1));
    send_pixel(make_pixel(8'h01, 8'h00, 8'h00, 8'h00, 1'b0));
    // extreme coefficients drive green negative
    send_request(make_write(mst_pkg::OP_COEF, 0, 1, -32768));
    send_request(make_write(mst_pkg::OP_COEF, 0, 2, 32767));
    send_request(make_write(mst_pkg::OP_COEF, 3, 6, -1));
    send_pixel(make_pixel(8'hff, 8'h80, 8'h7f, 8'h00, 1'b1));
    // drop: channel three and out-of-range addresses
    send_request(make_write(mst_pkg::OP_GAMMA, 3, 255, 0));
    send_request(make_write(mst_pkg::OP_GAMMA, 0, 256, 0));
    send_request(make_write(mst_pkg::OP_GAMMA, 2, 8191, 0));
    send_request(make_write(mst_pkg::OP_OTAB, 3, 8191, 0));
    send_request(make_write(mst_pkg::OP_COEF, 0, 9, 0));
    send_request(make_write(mst_pkg::OP_COEF, 3, 8191, 0));
    send_pixel(make_pixel(8'hff, 8'h80, 8'h7f, 8'h33, 1'b0));
    send_pixel(make_pixel(8'h01, 8'h80, 8'hff, 8'hcc, 1'b1));

    for (int p = 0; p < PHASES; p++) begin
      drain_pipeline();
      cfg_write <= 1'b1;
      cfg_index <= mst_pkg::CFG_SWAP;
      cfg_data  <= swap_plan[p];
      @(posedge clk);
      cfg_index <= mst_pkg::CFG_ALPHA;
      cfg_data  <= alpha_plan[p];
      @(posedge clk);
      cfg_write <= 1'b0;
      sb.set_config(mst_pkg::CFG_SWAP, swap_plan[p]);
      sb.set_config(mst_pkg::CFG_ALPHA, alpha_plan[p]);
      // one phase runs flat out on both sides
      src_idle_pct  = (p == 2) ? 0 : IDLE_PCT;
      sink_idle_pct = (p == 2) ? 0 : IDLE_PCT;
      phase_end     = sent + PHASE_ITEMS;
      while (sent < phase_end) send_random();
    end

    sink_idle_pct = IDLE_PCT;
    drain_pipeline();
    if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/mst_pkg.sv
hdl/mst_front.sv
hdl/mst_queue.sv
hdl/mst_back.sv
hdl/mst_outq.sv
hdl/matrix_shaper_color_transform.sv
hdl/mst_checker.sv
tb/tb_matrix_shaper_color_transform.sv
